// File: rtl/sfla_pkg.sv
// Shared widths, defaults and divider interface types for the slab free-list allocator.
`default_nettype none

package sfla_pkg;

	// Field widths fixed by the item formats
	localparam int ADDR_W   = 48;
	localparam int SIZE_W   = 14;
	localparam int NEED_W   = 15;
	localparam int STRIDE_W = 15;
	localparam int OP_W     = 2;
	localparam int STAT_W   = 2;

	// Default geometry
	localparam int SFLA_MAX_SLOTS    = 16384;
	localparam int SFLA_PAGE_BYTES   = 4096;
	localparam int SFLA_HEADER_BYTES = 16;
	localparam int SFLA_ALIGN_BYTES  = 8;

	// Slot-size steps that pick the region size in pages
	localparam int NEED_STEP0 = 64;
	localparam int NEED_STEP1 = 128;
	localparam int NEED_STEP2 = 512;
	localparam int NEED_STEP3 = 1024;
	localparam int PAGES0     = 64;
	localparam int PAGES1     = 32;
	localparam int PAGES2     = 16;
	localparam int PAGES3     = 8;
	localparam int PAGES4     = 4;

	// Divider: quotient bits retired per cycle and resulting cycle count
	localparam int DIV_STEPS  = 2;
	localparam int DIV_CYCLES = ADDR_W / DIV_STEPS;
	localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

	typedef struct packed {
		logic                start;
		logic [ADDR_W-1:0]   dividend;
		logic [STRIDE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [ADDR_W-1:0]   quo;
		logic [STRIDE_W-1:0] rem;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/sfla_divider.sv
// Multi-cycle restoring divider, two quotient bits per cycle.
`default_nettype none

module sfla_divider import sfla_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0]    quo_q;
	logic [STRIDE_W-1:0]  rem_q;
	logic [STRIDE_W-1:0]  dvs_q;
	logic [ADDR_W-1:0]    quo_nxt;
	logic [STRIDE_W-1:0]  rem_nxt;

	// Two dependent restoring steps per cycle
	always_comb begin
		logic [STRIDE_W:0]   t;
		logic [ADDR_W-1:0]   q;
		logic [STRIDE_W-1:0] r;
		q = quo_q;
		r = rem_q;
		t = '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			t = {r, q[ADDR_W-1]};
			q = {q[ADDR_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
				q[0] = 1'b1;
			end
			r = t[STRIDE_W-1:0];
		end
		quo_nxt = q;
		rem_nxt = r;
	end

	// Iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			// done pulses for one cycle after the last iteration
			done_q <= busy_q && !req.start && (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				quo_q <= quo_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

// File: rtl/slab_free_list_allocator_unit.sv
// Slab allocator: fixed-size slots over one region, free list with head and tail pointers.
//
// Channels: s_* carries commands (s_tuser = operation, s_tdata = object address),
// m_* carries one result per command (m_tuser = status, m_tdata = address and slot
// total). cfg_* writes object_size (index 0) and region_base (index 1); it is
// always ready and must only be used while no command is in flight.
// One command is worked at a time; s_tready is low from acceptance until the
// result has been moved into the output register.
// Steps from the accepting edge to m_tvalid:
//   allocate: one memory read, one multiply, one 48-bit add;
//   free: one pass through the shared divider (2 quotient bits a cycle), answered
//   sooner when the quotient shows a bad address;
//   create: one pass through the divider for the slot count,
//   then a sweep that links and clears one slot per cycle (up to MAX_SLOTS).
//   Empty-list allocates, frees before any create and the unused code go straight to the result.
// Without stalls the next command is accepted in the cycle after the result loads.
// Reset: no region exists; allocates report no free slot and frees report an
// invalid address until a create. The slot memories need no clearing at reset,
// since create sweeps every slot it makes reachable.
// Stall: a result waits in the output register while m_tready is low; the next
// command may be accepted meanwhile and completes once the register frees up.
`default_nettype none

module slab_free_list_allocator_unit import sfla_pkg::*; #(
	parameter  int MAX_SLOTS    = SFLA_MAX_SLOTS,
	parameter  int PAGE_BYTES   = SFLA_PAGE_BYTES,
	parameter  int HEADER_BYTES = SFLA_HEADER_BYTES,
	parameter  int ALIGN_BYTES  = SFLA_ALIGN_BYTES,
	localparam int CNT_W        = $clog2(MAX_SLOTS + 1),
	localparam int M_DATA_W     = ((ADDR_W + CNT_W + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration write channel
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [ADDR_W-1:0]   cfg_data,
	// command stream
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [ADDR_W-1:0]   s_tdata,  // [47:0] object_address
	input  wire logic [OP_W-1:0]     s_tuser,  // [1:0] operation
	// result stream
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // [47:0] result_address, then slot_total
	output logic [STAT_W-1:0]        m_tuser   // [1:0] status
);

	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int REG_W  = $clog2(PAGES0 * PAGE_BYTES + 1);
	localparam int PROD_W = SLOT_W + STRIDE_W;

	// Register indexes
	localparam logic CFG_OBJECT_SIZE = 1'b0;
	localparam logic CFG_REGION_BASE = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_CREATE = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOFREE  = 2'd1,
		ST_INVALID = 2'd2,
		ST_DOUBLE  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ALLOC_RD,
		S_ALLOC_SUM,
		S_FREE_GO,
		S_FREE_WAIT,
		S_FREE_RD,
		S_FREE_CHK,
		S_CR_CNT_GO,
		S_CR_CNT_WAIT,
		S_CR_SWEEP,
		S_RESP
	} state_t;

	state_t              state_q;
	logic [SIZE_W-1:0]   object_size_q;
	logic [ADDR_W-1:0]   region_base_q;
	logic [ADDR_W-1:0]   base_hdr_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [CNT_W-1:0]    count_q;
	logic [SLOT_W-1:0]   head_q;
	logic [SLOT_W-1:0]   tail_q;
	logic                list_empty_q;
	logic [REG_W-1:0]    region_q;
	logic [ADDR_W-1:0]   off_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    idx_q;
	logic [PROD_W-1:0]   prod_q;
	logic [ADDR_W-1:0]   pend_addr_q;
	status_t             pend_status_q;
	logic                m_valid_q;
	logic [ADDR_W-1:0]   m_addr_q;
	status_t             m_status_q;
	logic [CNT_W-1:0]    m_total_q;

	// slot memories
	logic [SLOT_W-1:0]   next_mem [MAX_SLOTS];
	logic                use_mem  [MAX_SLOTS];
	logic [SLOT_W-1:0]   next_rd_q;
	logic                use_rd_q;
	logic                next_we;
	logic [SLOT_W-1:0]   next_waddr;
	logic [SLOT_W-1:0]   next_wdata;
	logic                use_we;
	logic [SLOT_W-1:0]   use_waddr;
	logic                use_wdata;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic [NEED_W-1:0]   need_c;
	logic [REG_W-1:0]    region_c;
	logic [ADDR_W-1:0]   off_c;
	logic                quo_in_range;
	logic                quo_over_max;
	logic [CNT_W-1:0]    cnt_m1;
	logic [CNT_W-1:0]    idx_p1;
	logic                sweep_on;
	logic                resp_load;

	sfla_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Region size from the slot need
	assign need_c = NEED_W'(HEADER_BYTES) + NEED_W'(object_size_q);
	always_comb begin
		if (need_c <= NEED_W'(NEED_STEP0))      region_c = REG_W'(PAGES0 * PAGE_BYTES);
		else if (need_c <= NEED_W'(NEED_STEP1)) region_c = REG_W'(PAGES1 * PAGE_BYTES);
		else if (need_c <= NEED_W'(NEED_STEP2)) region_c = REG_W'(PAGES2 * PAGE_BYTES);
		else if (need_c <= NEED_W'(NEED_STEP3)) region_c = REG_W'(PAGES3 * PAGE_BYTES);
		else                                    region_c = REG_W'(PAGES4 * PAGE_BYTES);
	end

	// Offset of a freed address from the first object start
	assign off_c = s_tdata - base_hdr_q;

	// Quotient checks
	assign quo_in_range = (div_rsp.quo[ADDR_W-1:CNT_W] == '0) &&
	                      (div_rsp.quo[CNT_W-1:0] < count_q);
	assign quo_over_max = (div_rsp.quo[ADDR_W-1:CNT_W] != '0) ||
	                      (div_rsp.quo[CNT_W-1:0] > CNT_W'(MAX_SLOTS));
	assign cnt_m1   = count_q - CNT_W'(1);
	assign idx_p1   = idx_q + CNT_W'(1);
	assign sweep_on = (idx_q < count_q);

	// Result register loads when the previous result has left or is leaving
	assign resp_load = (state_q == S_RESP) && (!m_valid_q || m_tready);

	// Divider operand selection
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = off_q;
		div_req.divisor  = stride_q;
		unique case (state_q)
			S_FREE_GO: begin
				div_req.start = 1'b1;
			end
			S_CR_CNT_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = ADDR_W'(region_q);
			end
			default: begin
			end
		endcase
	end

	// Memory write ports
	always_comb begin
		next_we    = 1'b0;
		next_waddr = tail_q;
		next_wdata = slot_q;
		use_we     = 1'b0;
		use_waddr  = slot_q;
		use_wdata  = 1'b0;
		unique case (state_q)
			S_ALLOC_RD: begin
				use_we    = 1'b1;
				use_waddr = head_q;
				use_wdata = 1'b1;
			end
			S_FREE_CHK: begin
				use_we  = use_rd_q;
				next_we = use_rd_q && !list_empty_q;
			end
			S_CR_SWEEP: begin
				use_we     = sweep_on;
				use_waddr  = idx_q[SLOT_W-1:0];
				next_we    = sweep_on && (idx_p1 < count_q);
				next_waddr = idx_q[SLOT_W-1:0];
				next_wdata = idx_p1[SLOT_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
		next_rd_q <= next_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (use_we) begin
			use_mem[use_waddr] <= use_wdata;
		end
		use_rd_q <= use_mem[slot_q];
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			object_size_q <= SIZE_W'(64);
			region_base_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OBJECT_SIZE: object_size_q <= cfg_data[SIZE_W-1:0];
				CFG_REGION_BASE: region_base_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			base_hdr_q    <= ADDR_W'(HEADER_BYTES);
			stride_q      <= '0;
			count_q       <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			list_empty_q  <= 1'b1;
			region_q      <= '0;
			off_q         <= '0;
			slot_q        <= '0;
			idx_q         <= '0;
			prod_q        <= '0;
			pend_addr_q   <= '0;
			pend_status_q <= ST_OK;
			m_valid_q     <= 1'b0;
			m_addr_q      <= '0;
			m_status_q    <= ST_OK;
			m_total_q     <= '0;
		end else begin
			if (resp_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						pend_addr_q <= '0;
						unique case (op_t'(s_tuser))
							OP_ALLOC: begin
								if (list_empty_q) begin
									pend_status_q <= ST_NOFREE;
									state_q       <= S_RESP;
								end else begin
									pend_status_q <= ST_OK;
									state_q       <= S_ALLOC_RD;
								end
							end
							OP_FREE: begin
								off_q <= off_c;
								if (count_q == '0) begin
									pend_status_q <= ST_INVALID;
									state_q       <= S_RESP;
								end else begin
									pend_status_q <= ST_OK;
									state_q       <= S_FREE_GO;
								end
							end
							OP_CREATE: begin
								base_hdr_q    <= region_base_q + ADDR_W'(HEADER_BYTES);
								// round the slot need up to the alignment (a power of two)
								stride_q      <= (STRIDE_W'(need_c) + STRIDE_W'(ALIGN_BYTES - 1)) &
								                 ~STRIDE_W'(ALIGN_BYTES - 1);
								region_q      <= region_c;
								list_empty_q  <= 1'b1;
								pend_status_q <= ST_OK;
								state_q       <= S_CR_CNT_GO;
							end
							default: begin
								pend_status_q <= ST_OK;
								state_q       <= S_RESP;
							end
						endcase
					end
				end
				S_ALLOC_RD: begin
					prod_q  <= PROD_W'(head_q) * PROD_W'(stride_q);
					state_q <= S_ALLOC_SUM;
				end
				S_ALLOC_SUM: begin
					pend_addr_q <= base_hdr_q + ADDR_W'(prod_q);
					if (head_q == tail_q) begin
						list_empty_q <= 1'b1;
					end else begin
						head_q <= next_rd_q;
					end
					state_q <= S_RESP;
				end
				S_FREE_GO: begin
					state_q <= S_FREE_WAIT;
				end
				S_FREE_WAIT: begin
					if (div_rsp.done) begin
						if (div_rsp.rem != '0 || !quo_in_range) begin
							pend_status_q <= ST_INVALID;
							state_q       <= S_RESP;
						end else begin
							slot_q  <= div_rsp.quo[SLOT_W-1:0];
							state_q <= S_FREE_RD;
						end
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					if (!use_rd_q) begin
						pend_status_q <= ST_DOUBLE;
					end else begin
						if (list_empty_q) begin
							head_q       <= slot_q;
							list_empty_q <= 1'b0;
						end
						tail_q <= slot_q;
					end
					state_q <= S_RESP;
				end
				S_CR_CNT_GO: begin
					state_q <= S_CR_CNT_WAIT;
				end
				S_CR_CNT_WAIT: begin
					if (div_rsp.done) begin
						count_q <= quo_over_max ? CNT_W'(MAX_SLOTS) : div_rsp.quo[CNT_W-1:0];
						idx_q   <= '0;
						state_q <= S_CR_SWEEP;
					end
				end
				S_CR_SWEEP: begin
					if (sweep_on) begin
						idx_q <= idx_p1;
					end else begin
						head_q       <= '0;
						tail_q       <= (count_q == '0) ? '0 : cnt_m1[SLOT_W-1:0];
						list_empty_q <= (count_q == '0);
						state_q      <= S_RESP;
					end
				end
				S_RESP: begin
					if (resp_load) begin
						m_addr_q   <= pend_addr_q;
						m_status_q <= pend_status_q;
						m_total_q  <= count_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tuser   = m_status_q;

	always_comb begin
		m_tdata = '0;
		m_tdata[ADDR_W-1:0]          = m_addr_q;
		m_tdata[ADDR_W +: CNT_W]     = m_total_q;
	end

	// Free-list ends stay inside the region while the list holds slots
	a_head_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		!list_empty_q |-> (CNT_W'(head_q) < count_q))
		else $error("head slot beyond slot count");

	a_tail_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		!list_empty_q |-> (CNT_W'(tail_q) < count_q))
		else $error("tail slot beyond slot count");

	a_count_capped: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SLOTS))
		else $error("slot count above capacity");

	// A command is worked alone: input closes right after acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second command accepted while busy");

	// Any status other than ok carries a zero address
	a_nofree_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata[ADDR_W-1:0] == '0))
		else $error("failed command carries an address");

endmodule

`default_nettype wire
